FILE: rtl/double_ended_queue_unit_macros.svh
// Assertion macros shared by the deque RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge out of reset.
`define DQ_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("deque assertion failed");
// When ante holds, cons must hold at the same edge.
`define DQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque implication failed");
`else
`define DQ_ASSERT(lbl, clk, rst_n, cond)
`define DQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/dequ_pkg.sv
// Types and codes for the double-ended queue unit.
// No dependencies; imported by the top level.
package dequ_pkg;

    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_DUMP       = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0]       opcode;
        logic signed [VALUE_W-1:0] value;
    } t_deq_in;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] element;
        logic                      element_valid;
        logic [OCC_W-1:0]          occupancy;
        logic                      last;
    } t_deq_out;

endpackage

FILE: rtl/double_ended_queue_unit.sv
// Double-ended queue unit: ring store in a RAM, front index and element count.
// Uses dequ_pkg, dequ_ram and double_ended_queue_unit_macros.svh.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one command word:
// push front, pop front, push back, pop back or dump. Output channel
// (o_out_valid / i_out_stall / o_out_data) returns result words.
// Push and pop: one result word, registered, in the cycle after acceptance; a new
// command is taken every cycle while the output register drains.
// Dump of N elements: S_DUMP_RD reads the first, S_DUMP_WAIT registers it, then
// one word per cycle unless the receiver stalls, last flagged on the final one.
// The single RAM read port sets this rate. No command is accepted during a dump.
// Pops of an empty queue and pushes to a full one give a status word and leave
// the queue unchanged. A dump of an empty queue gives one empty-status word.
// While the receiver stalls a valid word, it holds and the input stalls too.
// Reset (synchronous, active low) empties the queue; RAM contents are left as
// they are and never read before being written.
`include "double_ended_queue_unit_macros.svh"
module double_ended_queue_unit
    import dequ_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_deq_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_deq_out o_out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE      = 2'd0;
    localparam logic [1:0] S_DUMP_RD   = 2'd1;
    localparam logic [1:0] S_DUMP_WAIT = 2'd2;

    logic [1:0]      r_state, n_state;
    logic [AW-1:0]   r_front, n_front;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_out_valid, n_out_valid;
    t_deq_out        r_out, n_out;

    logic                  out_free;
    logic                  in_acc;
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
    logic signed [63:0]    val_ext, rd_ext;
    logic [AW-1:0]         front_dec, front_inc;
    logic [AW-1:0]         rd_off, back_slot, rd_slot;
    logic [AW:0]           back_sum, rd_sum;
    logic                  full, empty, dump_last;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign full  = (r_count == CW'(DEPTH));
    assign empty = (r_count == '0);

    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);

    // ring wrap: both operands below DEPTH, so one conditional subtract
    assign back_sum  = {1'b0, r_front} + {1'b0, r_count[AW-1:0]};
    assign back_slot = (back_sum >= (AW+1)'(DEPTH)) ? AW'(back_sum - (AW+1)'(DEPTH))
                                                    : back_sum[AW-1:0];

    assign dump_last = ((r_idx + CW'(1)) == r_count);
    assign rd_off    = (r_state == S_DUMP_RD) ? r_idx[AW-1:0] : AW'(r_idx + CW'(1));
    assign rd_sum    = {1'b0, r_front} + {1'b0, rd_off};
    assign rd_slot   = (rd_sum >= (AW+1)'(DEPTH)) ? AW'(rd_sum - (AW+1)'(DEPTH))
                                                  : rd_sum[AW-1:0];

    assign val_ext   = 64'($signed(i_in_data.value));
    assign ram_wdata = val_ext[DATA_WIDTH-1:0];
    assign rd_ext    = 64'($signed(ram_rdata));

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = back_slot;
        ram_re      = 1'b0;
        ram_raddr   = rd_slot;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_out.status        = STAT_OK;
                    n_out.element       = '0;
                    n_out.element_valid = 1'b0;
                    n_out.last          = 1'b1;
                    n_out_valid         = 1'b1;
                    case (i_in_data.opcode)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            if (full) begin
                                n_out.status = STAT_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + CW'(1);
                                if (i_in_data.opcode == OP_PUSH_FRONT) begin
                                    n_front   = front_dec;
                                    ram_waddr = front_dec;
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (empty) begin
                                n_out.status = STAT_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                                if (i_in_data.opcode == OP_POP_FRONT) begin
                                    n_front = front_inc;
                                end
                            end
                        end
                        OP_DUMP: begin
                            if (empty) begin
                                n_out.status = STAT_EMPTY;
                            end else begin
                                n_out_valid = r_out_valid && i_out_stall;
                                n_idx       = '0;
                                n_state     = S_DUMP_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out.occupancy = OCC_W'(n_count);
                end
            end
            S_DUMP_RD: begin
                ram_re  = 1'b1;
                n_state = S_DUMP_WAIT;
            end
            S_DUMP_WAIT: begin
                if (out_free) begin
                    n_out.status        = STAT_OK;
                    n_out.element       = rd_ext[31:0];
                    n_out.element_valid = 1'b1;
                    n_out.occupancy     = OCC_W'(r_count);
                    n_out.last          = dump_last;
                    n_out_valid         = 1'b1;
                    if (dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        // fetch the next element while this one goes out
                        ram_re = 1'b1;
                        n_idx  = r_idx + CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    dequ_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `DQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `DQ_ASSERT(a_front_bound, i_clk, i_rst_n, r_front <= AW'(DEPTH - 1))
    `DQ_ASSERT_IMP(a_dump_idx, i_clk, i_rst_n, r_state != S_IDLE, r_idx < r_count)
    `DQ_ASSERT_IMP(a_write_idle, i_clk, i_rst_n, ram_we, r_state == S_IDLE && !full)

endmodule

FILE: rtl/dequ_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dequ_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: verif/tb_double_ended_queue_unit.sv
// Testbench for double_ended_queue_unit: directed script, then random command words.
// Every result word is checked against a shadow deque; depends on dequ_pkg and the RTL.
`timescale 1ns / 100ps

module tb_double_ended_queue_unit;
    import dequ_pkg::*;

    localparam int QDEPTH       = 16;
    localparam int IDX_W        = $clog2(QDEPTH);
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 300;
    localparam int MAX_SHOWN    = 10;
    localparam int DRAIN_CYCLES = 24;
    localparam int IDLE_PCT     = 29;
    localparam int DUE_DEPTH    = 256;

    // opcodes the block answers with an OK word and otherwise ignores
    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct {
        logic [OPCODE_W-1:0] opcode;
        logic [VALUE_W-1:0]  value;
        int                  reps;
        bit                  typed;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occ;
    } t_script_row;

    // typed rows carry a one-word result that is obvious from the operation
    t_script_row script [16] = '{
        '{OP_POP_FRONT,  32'h0000_0000, 1,  1'b1, STAT_EMPTY, 5'd0},
        '{OP_POP_BACK,   32'hFFFF_FFFF, 1,  1'b1, STAT_EMPTY, 5'd0},
        '{OP_DUMP,       32'h0000_0000, 1,  1'b1, STAT_EMPTY, 5'd0},
        '{OP_SPARE_LO,   32'h5A5A_5A5A, 1,  1'b1, STAT_OK,    5'd0},
        '{OP_PUSH_BACK,  32'h7FFF_FFFF, 1,  1'b1, STAT_OK,    5'd1},
        '{OP_PUSH_FRONT, 32'h8000_0000, 1,  1'b1, STAT_OK,    5'd2},
        '{OP_PUSH_BACK,  32'h0000_0000, 1,  1'b1, STAT_OK,    5'd3},
        '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1,  1'b1, STAT_OK,    5'd4},
        '{OP_DUMP,       32'h0000_0000, 1,  1'b0, STAT_OK,    5'd4},
        '{OP_SPARE_HI,   32'hFFFF_FFFF, 1,  1'b1, STAT_OK,    5'd4},
        '{OP_POP_FRONT,  32'h0000_0000, 1,  1'b1, STAT_OK,    5'd3},
        '{OP_POP_BACK,   32'h0000_0000, 1,  1'b1, STAT_OK,    5'd2},
        '{OP_PUSH_BACK,  32'h1000_0000, 14, 1'b0, STAT_OK,    5'd16},
        '{OP_PUSH_FRONT, 32'h1234_5678, 1,  1'b1, STAT_FULL,  5'd16},
        '{OP_PUSH_BACK,  32'h8765_4321, 1,  1'b1, STAT_FULL,  5'd16},
        '{OP_DUMP,       32'h0000_0000, 1,  1'b0, STAT_OK,    5'd16}
    };

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_stall;
    t_deq_in  in_data   = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_deq_out out_data;

    logic no_gaps = 1'b0;
    int   mismatches  = 0;
    int   cycle_count = 0;

    // shadow deque
    logic [VALUE_W-1:0] shadow_ring [QDEPTH];
    logic [IDX_W-1:0]   shadow_head  = '0;
    logic [OCC_W-1:0]   shadow_count = '0;

    // expected result words, in order, as a ring with free-running pointers
    t_deq_out due_ring [DUE_DEPTH];
    int       due_wr = 0;
    int       due_rd = 0;

    double_ended_queue_unit #(
        .DEPTH      (QDEPTH),
        .DATA_WIDTH (VALUE_W)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic t_deq_out result_word(logic [STATUS_W-1:0] status,
                                             logic [VALUE_W-1:0] elem,
                                             logic vld, logic last);
        t_deq_out r;
        r.status        = status;
        r.element       = elem;
        r.element_valid = vld;
        r.occupancy     = shadow_count;
        r.last          = last;
        return r;
    endfunction

    function automatic void due_add(t_deq_out w);
        due_ring[due_wr % DUE_DEPTH] = w;
        due_wr++;
    endfunction

    task automatic shadow_deque_step(input t_deq_in w);
        logic [IDX_W-1:0] slot;
        case (w.opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (shadow_count == QDEPTH) begin
                    due_add(result_word(STAT_FULL, '0, 1'b0, 1'b1));
                end else begin
                    if (w.opcode == OP_PUSH_FRONT) begin
                        shadow_head = shadow_head - 1'b1;
                        slot = shadow_head;
                    end else begin
                        slot = shadow_head + shadow_count[IDX_W-1:0];
                    end
                    shadow_ring[slot] = w.value;
                    shadow_count = shadow_count + 1'b1;
                    due_add(result_word(STAT_OK, '0, 1'b0, 1'b1));
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (shadow_count == 0) begin
                    due_add(result_word(STAT_EMPTY, '0, 1'b0, 1'b1));
                end else begin
                    if (w.opcode == OP_POP_FRONT)
                        shadow_head = shadow_head + 1'b1;
                    shadow_count = shadow_count - 1'b1;
                    due_add(result_word(STAT_OK, '0, 1'b0, 1'b1));
                end
            end
            OP_DUMP: begin
                if (shadow_count == 0) begin
                    due_add(result_word(STAT_EMPTY, '0, 1'b0, 1'b1));
                end else begin
                    for (int i = 0; i < shadow_count; i++) begin
                        slot = shadow_head + IDX_W'(i);
                        due_add(result_word(STAT_OK, shadow_ring[slot], 1'b1,
                                            (i == shadow_count - 1)));
                    end
                end
            end
            default: begin
                due_add(result_word(STAT_OK, '0, 1'b0, 1'b1));
            end
        endcase
    endtask

    // random gap, then hold the word until it is taken
    task automatic send_word(input t_deq_in w);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (in_stall);
        shadow_deque_step(w);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(7) != 0)
            return $urandom;
        case ($urandom_range(3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    always @(posedge clk) begin
        out_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk) begin
        t_deq_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (due_wr == due_rd) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("extra word: status=%0d element=%h vld=%b occ=%0d last=%b",
                             out_data.status, out_data.element, out_data.element_valid,
                             out_data.occupancy, out_data.last);
            end else begin
                want = due_ring[due_rd % DUE_DEPTH];
                due_rd++;
                if (out_data.status !== want.status || out_data.element !== want.element ||
                    out_data.element_valid !== want.element_valid ||
                    out_data.occupancy !== want.occupancy || out_data.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display("mismatch at %0t:", $realtime);
                        $display("  exp status=%0d element=%h vld=%b occ=%0d last=%b",
                                 want.status, want.element, want.element_valid,
                                 want.occupancy, want.last);
                        $display("  got status=%0d element=%h vld=%b occ=%0d last=%b",
                                 out_data.status, out_data.element, out_data.element_valid,
                                 out_data.occupancy, out_data.last);
                    end
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        t_deq_in  w;
        t_deq_out typed_word;
        int       roll;
        int       push_pct;

        push_pct = 80;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[r]) begin
            for (int k = 0; k < script[r].reps; k++) begin
                w.opcode = script[r].opcode;
                w.value  = script[r].value + k;
                send_word(w);
                if (script[r].typed) begin
                    typed_word = '{status: script[r].status, element: '0, element_valid: 1'b0,
                                   occupancy: script[r].occ, last: 1'b1};
                    // typed result replaces the one just predicted
                    due_ring[(due_wr - 1) % DUE_DEPTH] = typed_word;
                end
            end
        end

        // pick fill-heavy or drain-heavy stretches at random so full and empty both recur
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 50 == 0)
                push_pct = $urandom_range(1) ? 80 : 20;
            no_gaps <= (n >= 120 && n < 200);
            roll = $urandom_range(99);
            if (roll < 4)
                w.opcode = OPCODE_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
            else if (roll < 12)
                w.opcode = OP_DUMP;
            else if ($urandom_range(99) < push_pct)
                w.opcode = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            else
                w.opcode = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
            w.value = pick_value();
            send_word(w);
        end
        in_valid <= 1'b0;

        while (due_wr != due_rd)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: double_ended_queue_unit.f
+incdir+rtl
rtl/dequ_pkg.sv
rtl/dequ_ram.sv
rtl/double_ended_queue_unit.sv
verif/tb_double_ended_queue_unit.sv
